FILE: rtl/sfr_pkg.sv
package sfr_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam int BUF_DEPTH = 15;
	localparam int LEN_CAP = BUF_DEPTH + 1;

	typedef enum logic [2:0] {
		ST_SYNC1,
		ST_SYNC2,
		ST_LEN,
		ST_INSTR,
		ST_DATA,
		ST_CSUM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr_frame;
		logic store_len;
		logic store_instr;
		logic store_data;
		logic capture_ok;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic is_sync;
		logic len_ok;
		logic len_gt1;
		logic data_done;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/sfr_ctrl.sv
module sfr_ctrl
	import sfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC1;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = (state_q != ST_EMIT);
		accept   = s_tvalid && s_tready;
		case (state_q)
			ST_SYNC1: begin
				if (accept && st.is_sync) begin
					cmd.clr_frame = 1'b1;
					state_d       = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				if (accept) begin
					if (st.is_sync) begin
						cmd.clr_frame = 1'b1;
						state_d       = ST_LEN;
					end else begin
						state_d = ST_SYNC1;
					end
				end
			end
			ST_LEN: begin
				if (accept) begin
					if (st.len_ok) begin
						cmd.store_len = 1'b1;
						state_d       = ST_INSTR;
					end else begin
						state_d = ST_SYNC1;
					end
				end
			end
			ST_INSTR: begin
				if (accept) begin
					cmd.store_instr = 1'b1;
					state_d         = st.len_gt1 ? ST_DATA : ST_CSUM;
				end
			end
			ST_DATA: begin
				if (accept) begin
					cmd.store_data = 1'b1;
					if (st.data_done) begin
						state_d = ST_CSUM;
					end
				end
			end
			ST_CSUM: begin
				if (accept) begin
					cmd.capture_ok = 1'b1;
					state_d        = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit_load = 1'b1;
					if (st.emit_last) begin
						state_d = ST_SYNC1;
					end
				end
			end
			default: begin
				state_d = ST_SYNC1;
			end
		endcase
	end

endmodule

FILE: rtl/sfr_dp.sv
module sfr_dp
	import sfr_pkg::*;
#(
	parameter logic [7:0] LEN_LIMIT = 8'd16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  cmd_t        cmd,
	output status_t     st,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  instruction,
	output logic [3:0]  data_count,
	output logic        has_data,
	output logic [3:0]  data_index,
	output logic [7:0]  data_byte,
	output logic        checksum_ok,
	output logic        last
);

	logic [4:0] len_q;
	logic [7:0] instr_q;
	logic [3:0] cnt_q;
	logic [7:0] sum_q;
	logic       ok_q;
	logic [3:0] idx_q;
	logic [7:0] mem [BUF_DEPTH];

	logic       out_valid_q;
	logic [7:0] out_instr_q;
	logic [3:0] out_count_q;
	logic       out_has_q;
	logic [3:0] out_index_q;
	logic [7:0] out_byte_q;
	logic       out_ok_q;
	logic       out_last_q;

	logic [3:0] count_w;
	logic [4:0] cnt_next;

	assign count_w  = (len_q > 5'd1) ? 4'(len_q - 5'd1) : 4'd0;
	assign cnt_next = {1'b0, cnt_q} + 5'd1;

	always_comb begin
		st.is_sync   = (rx_byte == SYNC_BYTE);
		st.len_ok    = (rx_byte <= LEN_LIMIT);
		st.len_gt1   = (len_q > 5'd1);
		st.data_done = ((cnt_next + 5'd1) >= len_q) || (cnt_next >= 5'(BUF_DEPTH));
		st.emit_last = (count_w == 4'd0) || (idx_q == (count_w - 4'd1));
		st.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			instr_q     <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			ok_q        <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_frame) begin
				cnt_q   <= '0;
				instr_q <= '0;
				sum_q   <= '0;
			end
			if (cmd.store_len) begin
				len_q <= rx_byte[4:0];
				sum_q <= rx_byte;
			end
			if (cmd.store_instr) begin
				instr_q <= rx_byte;
				sum_q   <= sum_q + rx_byte;
			end
			if (cmd.store_data) begin
				cnt_q <= cnt_next[3:0];
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.capture_ok) begin
				ok_q  <= (rx_byte == ~sum_q);
				idx_q <= '0;
			end
			if (cmd.emit_load) begin
				idx_q       <= idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_data) begin
			mem[cnt_q] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_instr_q <= instr_q;
			out_count_q <= count_w;
			out_has_q   <= (count_w != 4'd0);
			out_index_q <= (count_w != 4'd0) ? idx_q : 4'd0;
			out_byte_q  <= (count_w != 4'd0) ? mem[idx_q] : 8'd0;
			out_ok_q    <= ok_q;
			out_last_q  <= st.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign instruction = out_instr_q;
	assign data_count  = out_count_q;
	assign has_data    = out_has_q;
	assign data_index  = out_index_q;
	assign data_byte   = out_byte_q;
	assign checksum_ok = out_ok_q;
	assign last        = out_last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!out_valid_q || out_ready))
		else $error("result word overwritten before taken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load && st.emit_last) |=> (out_valid_q && out_last_q))
		else $error("final result word lost its last flag");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_has_q) |-> (out_index_q < out_count_q))
		else $error("data index beyond data count");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_data |-> ({1'b0, cnt_q} < 5'(BUF_DEPTH)))
		else $error("payload buffer overrun");

endmodule

FILE: rtl/serial_frame_receiver_top.sv
// Result: after the checksum word is accepted, the emit state loads the first result
// word into the output register once that register is free.
// Throughput: one received word per cycle through sync, length, instruction and data.
// Frame end: input stalls as max(1, data count) results drain from the payload
// buffer, one per cycle while the output register is free; m_tready low holds it.
// Reset: arst_n asynchronous, active low; parser returns to first sync, no result valid.
module serial_frame_receiver_top
	import sfr_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] instruction, [11:8] data_count, [12] has_data, [16:13] data_index,
	// [24:17] data_byte, [25] checksum_ok, [31:26] zero
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	localparam int LenLimit = (MAX_FRAME_LEN < LEN_CAP) ? MAX_FRAME_LEN : LEN_CAP;

	cmd_t       cmd;
	status_t    st;
	logic [7:0] instruction;
	logic [3:0] data_count;
	logic       has_data;
	logic [3:0] data_index;
	logic [7:0] data_byte;
	logic       checksum_ok;

	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sfr_dp #(
		.LEN_LIMIT (8'(LenLimit))
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (s_tdata),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.instruction (instruction),
		.data_count  (data_count),
		.has_data    (has_data),
		.data_index  (data_index),
		.data_byte   (data_byte),
		.checksum_ok (checksum_ok),
		.last        (m_tlast)
	);

	assign m_tdata = {6'd0, checksum_ok, data_byte, data_index, has_data, data_count,
		instruction};

endmodule
